>>> rtl/dqnp_pkg.sv
// ----------------------------------------------------------------------------
// dqnp_pkg: shared types and constants for the DNS question name parser
// Holds the phase and result codes, the parser state and result word records
// and the header and label limits used by the modules of the block.
// ----------------------------------------------------------------------------
package dqnp_pkg;

	localparam int unsigned HeaderBytes = 12;
	localparam int unsigned LabelLimit  = 64;

	localparam logic [7:0] DotChar = 8'h2E;

	// Parser phases.
	localparam logic [2:0] PH_HEADER    = 3'd0;
	localparam logic [2:0] PH_LENGTH    = 3'd1;
	localparam logic [2:0] PH_LABEL     = 3'd2;
	localparam logic [2:0] PH_TYPECLASS = 3'd3;
	localparam logic [2:0] PH_TRAILER   = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_BADLEN = 2'd2;
	localparam logic [1:0] KIND_EARLY  = 2'd3;

	typedef struct packed {
		logic [2:0]  phase;
		logic [5:0]  count;
		logic        first_label;
		logic [23:0] type_class;
	} parse_state_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  name_char;
		logic [15:0] query_type;
		logic [15:0] query_class;
	} result_word_t;

	localparam parse_state_t StateReset = '{
		phase:       PH_HEADER,
		count:       6'd0,
		first_label: 1'b1,
		type_class:  24'd0
	};

endpackage

>>> rtl/dqnp_if.sv
// ----------------------------------------------------------------------------
// dqnp_byte_if / dqnp_result_if: valid-ready channels of the parser
// The byte channel carries one message byte and its end mark; the result
// channel carries one parser result word.
// ----------------------------------------------------------------------------
interface dqnp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source (output valid, output data_byte, output end_of_packet, input ready);
	modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface dqnp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  name_char;
	logic [15:0] query_type;
	logic [15:0] query_class;

	modport source (output valid, output result_kind, output name_char,
		output query_type, output query_class, input ready);
	modport sink (input valid, input result_kind, input name_char,
		input query_type, input query_class, output ready);
endinterface

>>> rtl/dns_question_name_parser.sv
// ----------------------------------------------------------------------------
// dns_question_name_parser: streaming parser of the first DNS question name
// Takes a DNS message a byte per word and reports the name characters,
// the query type and class, and malformed-message errors.
// ----------------------------------------------------------------------------
// Usage:
//   The data channel takes one message byte per word, with end_of_packet set
//   on the last byte. The first twelve bytes (the header) are skipped. Each
//   byte of the first question name then yields a result word of kind 0
//   carrying the character, with a dot word between labels. After the zero
//   terminator, the fourth type and class byte yields one kind 1 word with
//   query_type and query_class. A label length of 64 or more yields kind 2,
//   and an end mark before the question is complete yields kind 3. Bytes
//   after the question or after an error give no word; every end mark
//   returns the parser to the header phase.
//   Throughput is one byte per cycle while the receiver keeps taking results.
//   A byte is registered at acceptance, in the input stage or, during a stall,
//   in the skid register, and its result word, if any, is loaded into the
//   output register when the input stage moves on. The step logic is a
//   single pass between the input register and the output register. When
//   the receiver stalls, a one-word skid register on the input side absorbs
//   one more byte, and then ready drops until the output register drains.
//   Reset clears all valid flags and puts the parser in the header phase
//   with no label seen.
// ----------------------------------------------------------------------------
module dns_question_name_parser
	import dqnp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	dqnp_byte_if.sink     data,
	dqnp_result_if.source result
);

	// Skid register in front of the input stage.
	logic         skid_valid_q;
	logic [7:0]   skid_byte_q;
	logic         skid_eop_q;

	// Input stage.
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         eop_s1;

	// Parser state and output register.
	parse_state_t state_q;
	logic         out_valid_q;
	result_word_t out_word_q;

	parse_state_t next_state;
	logic         has_result;
	result_word_t step_word;

	logic         accept_in;
	logic         out_free;
	logic         advance;
	logic         load_s1;

	assign data.ready = !skid_valid_q;
	assign accept_in  = data.valid && data.ready;
	assign out_free   = !out_valid_q || result.ready;
	assign advance    = valid_s1 && out_free;
	// The input stage takes a new byte whenever it is empty or moving on.
	assign load_s1    = !valid_s1 || out_free;

	dqnp_step u_step (
		.state        (state_q),
		.data_byte    (byte_s1),
		.end_of_packet(eop_s1),
		.next_state   (next_state),
		.has_result   (has_result),
		.result       (step_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1     <= skid_valid_q || accept_in;
				skid_valid_q <= 1'b0;
			end else if (accept_in) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			if (skid_valid_q) begin
				byte_s1 <= skid_byte_q;
				eop_s1  <= skid_eop_q;
			end else begin
				byte_s1 <= data.data_byte;
				eop_s1  <= data.end_of_packet;
			end
		end else if (accept_in) begin
			skid_byte_q <= data.data_byte;
			skid_eop_q  <= data.end_of_packet;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StateReset;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= next_state;
				out_valid_q <= has_result;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_word_q <= step_word;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.result_kind = out_word_q.result_kind;
	assign result.name_char   = out_word_q.name_char;
	assign result.query_type  = out_word_q.query_type;
	assign result.query_class = out_word_q.query_class;

	// The skid register only fills behind an occupied input stage.
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> valid_s1)
		else $error("skid register holds a byte while the input stage is empty");

	// A label in progress always has bytes left to take.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_LABEL) |-> (state_q.count != 6'd0))
		else $error("label phase with zero bytes remaining");

	// No more than three type and class bytes are ever held.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_TYPECLASS) |-> (state_q.count <= 6'd3))
		else $error("type and class byte count overran");

	// The header phase is only entered with the first-label flag set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_HEADER) |-> state_q.first_label)
		else $error("header phase with first-label flag cleared");

endmodule

>>> rtl/dqnp_step.sv
// ----------------------------------------------------------------------------
// dqnp_step: next-state and result logic of the parser
// Given the current parser state and one message byte, computes the state
// after that byte and the result word it produces, if any.
// ----------------------------------------------------------------------------
module dqnp_step
	import dqnp_pkg::*;
(
	input  parse_state_t state,
	input  logic [7:0]   data_byte,
	input  logic         end_of_packet,
	output parse_state_t next_state,
	output logic         has_result,
	output result_word_t result
);

	logic [5:0] count_inc;
	logic [5:0] count_dec;
	logic       finished;

	assign count_inc = state.count + 6'd1;
	assign count_dec = state.count - 6'd1;

	always_comb begin
		next_state = state;
		has_result = 1'b0;
		result     = '0;
		finished   = 1'b0;

		unique case (state.phase)
			PH_HEADER: begin
				next_state.count = count_inc;
				if (count_inc >= 6'(HeaderBytes)) begin
					next_state.phase = PH_LENGTH;
					next_state.count = 6'd0;
				end
			end
			PH_LENGTH: begin
				if (data_byte == 8'd0) begin
					next_state.phase      = PH_TYPECLASS;
					next_state.count      = 6'd0;
					next_state.type_class = 24'd0;
				end else if (data_byte >= 8'(LabelLimit)) begin
					has_result         = 1'b1;
					result.result_kind = KIND_BADLEN;
					next_state.phase   = PH_TRAILER;
					finished           = 1'b1;
				end else begin
					if (!state.first_label) begin
						has_result         = 1'b1;
						result.result_kind = KIND_CHAR;
						result.name_char   = DotChar;
					end
					next_state.first_label = 1'b0;
					next_state.count       = data_byte[5:0];
					next_state.phase       = PH_LABEL;
				end
			end
			PH_LABEL: begin
				has_result         = 1'b1;
				result.result_kind = KIND_CHAR;
				result.name_char   = data_byte;
				next_state.count   = count_dec;
				if (count_dec == 6'd0) begin
					next_state.phase = PH_LENGTH;
				end
			end
			PH_TYPECLASS: begin
				if (state.count >= 6'd3) begin
					has_result         = 1'b1;
					result.result_kind = KIND_DONE;
					result.query_type  = state.type_class[23:8];
					result.query_class = {state.type_class[7:0], data_byte};
					next_state.phase   = PH_TRAILER;
					finished           = 1'b1;
				end else begin
					next_state.type_class = {state.type_class[15:0], data_byte};
					next_state.count      = count_inc;
				end
			end
			default: begin
				// Trailer and the unused codes: bytes are dropped.
				finished = 1'b1;
			end
		endcase

		if (end_of_packet) begin
			if (!finished) begin
				has_result         = 1'b1;
				result             = '0;
				result.result_kind = KIND_EARLY;
			end
			next_state = StateReset;
		end
	end

endmodule
